// ----- rtl/core/bfsk_pkg.sv -----
// ----------------------------------------------------------------------------
// bfsk_pkg
// Shared constants, register indexes and the quarter-wave sine generator used
// by the binary FSK I/Q modulator core.
// ----------------------------------------------------------------------------
package bfsk_pkg;

  // Default structural parameters
  localparam int FRAME_BITS_DEF    = 64;
  localparam int TAB_ADDR_BITS_DEF = 10;

  // Fixed field widths
  localparam int DATA_WORD_W = 64;
  localparam int SPB_W       = 20;
  localparam int STEP_W      = 32;
  localparam int AMP_W       = 15;
  localparam int MAG_W       = 15;
  localparam int SAMPLE_W    = 16;
  localparam int BIT_POS_W   = 6;
  localparam int PHASE_W     = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DATA_WORD       = 2'd0,
    REG_SAMPLES_PER_BIT = 2'd1,
    REG_PHASE_STEP      = 2'd2,
    REG_AMPLITUDE       = 2'd3
  } cfg_reg_t;

  // Register reset values
  localparam logic [DATA_WORD_W-1:0] DATA_WORD_RST = 64'hAB42_F58C_15AC_FE37;
  localparam logic [SPB_W-1:0]       SPB_RST       = 20'd80000;
  localparam logic [STEP_W-1:0]      STEP_RST      = 32'd2684355;
  localparam logic [AMP_W-1:0]       AMP_RST       = 15'd2000;

  // pi/2 in Q40
  localparam logic [63:0] HALF_PI_Q40 = 64'h0000_0192_1FB5_4443;

  // Entry k of a quarter-wave table with Q = 2^abits steps: 32767*sin(k*pi/(2Q)),
  // built from an integer Taylor series. Evaluated at elaboration only.
  function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned k,
                                                    input int unsigned abits);
    logic [63:0]        rnd;
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    rnd  = (64'd1 << (abits + 10)) >> 1;
    x    = (64'(k) * HALF_PI_Q40 + rnd) >> (abits + 10);
    sum  = signed'(x);
    term = x;
    for (int n = 1; n <= 8; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        7:       term = term / 64'd210;
        default: term = term / 64'd272;
      endcase
      if ((n & 1) != 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[MAG_W-1:0];
  endfunction

endpackage

// ----- rtl/core/bfsk_channel_if.sv -----
// ----------------------------------------------------------------------------
// bfsk_channel_if
// Valid/ready channels of the modulator: sample request in, I/Q sample out.
// ----------------------------------------------------------------------------
interface bfsk_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface bfsk_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bfsk_pkg::SAMPLE_W-1:0] first_component;
  logic signed [bfsk_pkg::SAMPLE_W-1:0] second_component;
  logic                                current_bit;
  logic                                last_of_frame;

  modport source (output valid, output first_component, output second_component,
                  output current_bit, output last_of_frame, input ready);
  modport sink   (input valid, input first_component, input second_component,
                  input current_bit, input last_of_frame, output ready);
endinterface

// ----- rtl/core/bfsk_sine_rom.sv -----
// ----------------------------------------------------------------------------
// bfsk_sine_rom
// Quarter-wave sine table with two registered read ports.
// ----------------------------------------------------------------------------
module bfsk_sine_rom #(
  parameter int TABLE_ADDRESS_BITS = bfsk_pkg::TAB_ADDR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic [TABLE_ADDRESS_BITS:0]         addr_a,
  input  logic [TABLE_ADDRESS_BITS:0]         addr_b,
  output logic [bfsk_pkg::MAG_W-1:0]          data_a,
  output logic [bfsk_pkg::MAG_W-1:0]          data_b
);

  localparam int Depth = (1 << TABLE_ADDRESS_BITS) + 1;

  logic [bfsk_pkg::MAG_W-1:0] rom [Depth];
  logic [bfsk_pkg::MAG_W-1:0] data_a_r;
  logic [bfsk_pkg::MAG_W-1:0] data_b_r;

  // Fill the table with constants
  for (genvar k = 0; k < Depth; k++) begin : g_rom
    assign rom[k] = bfsk_pkg::quarter_sine(k, TABLE_ADDRESS_BITS);
  end

  // Read both ports, hold on stall
  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_a_r <= rom[addr_a];
      data_b_r <= rom[addr_b];
    end
  end

  assign data_a = data_a_r;
  assign data_b = data_b_r;

endmodule

// ----- rtl/core/binary_fsk_iq_modulator_core.sv -----
// ----------------------------------------------------------------------------
// binary_fsk_iq_modulator_core
// Binary FSK baseband modulator producing one complex sample per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Each transaction on in_ch requests one I/Q sample; restart=1 restarts
//   the frame at bit 0, sample 0, phase 0 before that sample is formed.
//   out_ch returns first_component (sine part, sign set by the data bit),
//   second_component (cosine part), current_bit and last_of_frame.
//   The data word is sent LSB first, samples_per_bit samples per bit, and
//   the frame repeats without a gap.
//   cfg_we/cfg_index/cfg_data write the four registers; write only while no
//   sample is in flight.
// Timing:
//   An accepted request reaches out_ch.valid through three registers: lookup
//   register, registered table read, multiply output.
//   Throughput is one sample per cycle while out_ch.ready stays high.
// Reset:
//   rst_n clears the frame position, the phase and all stage valid flags and
//   loads the register defaults.
// Stall:
//   Each stage advances when it is empty or the one after it advances, so up
//   to three samples are held while out_ch.ready is low before in_ch.ready
//   drops.
// ----------------------------------------------------------------------------
module binary_fsk_iq_modulator_core #(
  parameter int FRAME_BITS         = bfsk_pkg::FRAME_BITS_DEF,
  parameter int TABLE_ADDRESS_BITS = bfsk_pkg::TAB_ADDR_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  bfsk_in_if.sink                            in_ch,
  bfsk_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [bfsk_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bfsk_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IdxW = TABLE_ADDRESS_BITS + 1;
  localparam logic [IdxW-1:0] TabQ = {1'b1, {TABLE_ADDRESS_BITS{1'b0}}};
  localparam logic [bfsk_pkg::BIT_POS_W:0] FrameLen = (bfsk_pkg::BIT_POS_W + 1)'(FRAME_BITS);

  // Configuration registers
  logic [bfsk_pkg::DATA_WORD_W-1:0] data_word_r;
  logic [bfsk_pkg::SPB_W-1:0]       spb_r;
  logic [bfsk_pkg::STEP_W-1:0]      step_r;
  logic [bfsk_pkg::AMP_W-1:0]       amp_r;

  // Frame state
  logic [bfsk_pkg::BIT_POS_W-1:0] bit_pos_r, bit_pos_nxt;
  logic [bfsk_pkg::SPB_W-1:0]     sample_r, sample_nxt;
  logic [bfsk_pkg::PHASE_W-1:0]   phase_r, phase_nxt;

  // Pipeline handshake
  logic in_acc;
  logic s1_load, s2_load, out_load;

  // Stage 1: table addresses and flags
  logic            s1_v_r;
  logic [IdxW-1:0] s1_sidx_r, s1_cidx_r;
  logic            s1_sneg_r, s1_cneg_r, s1_bit_r, s1_last_r;

  // Stage 2: table data and flags
  logic                        s2_v_r;
  logic                        s2_sneg_r, s2_cneg_r, s2_bit_r, s2_last_r;
  logic [bfsk_pkg::MAG_W-1:0]  smag, cmag;

  // Output register
  logic                                 out_v_r;
  logic signed [bfsk_pkg::SAMPLE_W-1:0] first_r, second_r;
  logic                                 bit_r, last_r;

  // Current-sample combinational values
  logic [bfsk_pkg::BIT_POS_W-1:0] bp0;
  logic [bfsk_pkg::SPB_W-1:0]     smp0;
  logic [bfsk_pkg::PHASE_W-1:0]   ph0;
  logic [bfsk_pkg::SPB_W-1:0]     spb_eff;
  logic                           cur_bit, ends, last;
  logic [1:0]                     squad, cquad;
  logic [IdxW-1:0]                raw_idx, sidx, cidx;

  // Products
  logic [2*bfsk_pkg::MAG_W-1:0] sprod, cprod;
  logic [bfsk_pkg::MAG_W-1:0]   sscaled, cscaled;
  logic signed [bfsk_pkg::SAMPLE_W-1:0] first_nxt, second_nxt;

  // Ready chain, back from the output register
  assign out_load    = !out_v_r || out_ch.ready;
  assign s2_load     = !s2_v_r || out_load;
  assign s1_load     = !s1_v_r || s2_load;
  assign in_ch.ready = s1_load;
  assign in_acc      = in_ch.valid && s1_load;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_word_r <= bfsk_pkg::DATA_WORD_RST;
      spb_r       <= bfsk_pkg::SPB_RST;
      step_r      <= bfsk_pkg::STEP_RST;
      amp_r       <= bfsk_pkg::AMP_RST;
    end else if (cfg_we) begin
      case (bfsk_pkg::cfg_reg_t'(cfg_index))
        bfsk_pkg::REG_DATA_WORD:       data_word_r <= cfg_data;
        bfsk_pkg::REG_SAMPLES_PER_BIT: spb_r       <= cfg_data[bfsk_pkg::SPB_W-1:0];
        bfsk_pkg::REG_PHASE_STEP:      step_r      <= cfg_data[bfsk_pkg::STEP_W-1:0];
        bfsk_pkg::REG_AMPLITUDE:       amp_r       <= cfg_data[bfsk_pkg::AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame position and phase for this sample, then advance
  always_comb begin
    bp0     = in_ch.restart ? '0 : bit_pos_r;
    smp0    = in_ch.restart ? '0 : sample_r;
    ph0     = in_ch.restart ? '0 : phase_r;
    spb_eff = (spb_r == '0) ? bfsk_pkg::SPB_W'(1) : spb_r;
    cur_bit = data_word_r[bp0];
    ends    = ({1'b0, smp0} + 21'd1) >= {1'b0, spb_eff};
    last    = ends && (({1'b0, bp0} + 7'd1) >= FrameLen);

    if (ends) begin
      sample_nxt  = '0;
      phase_nxt   = '0;
      bit_pos_nxt = last ? '0 : bp0 + 6'd1;
    end else begin
      sample_nxt  = smp0 + 20'd1;
      phase_nxt   = ph0 + step_r;
      bit_pos_nxt = bp0;
    end

    // Quadrant fold; cosine is a quarter turn ahead
    squad   = ph0[31:30];
    cquad   = squad + 2'd1;
    raw_idx = {1'b0, ph0[29 -: TABLE_ADDRESS_BITS]};
    sidx    = squad[0] ? TabQ - raw_idx : raw_idx;
    cidx    = cquad[0] ? TabQ - raw_idx : raw_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_pos_r <= '0;
      sample_r  <= '0;
      phase_r   <= '0;
    end else if (in_acc) begin
      bit_pos_r <= bit_pos_nxt;
      sample_r  <= sample_nxt;
      phase_r   <= phase_nxt;
    end
  end

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_load) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_sidx_r <= sidx;
      s1_cidx_r <= cidx;
      s1_sneg_r <= squad[1] ^ !cur_bit;
      s1_cneg_r <= cquad[1];
      s1_bit_r  <= cur_bit;
      s1_last_r <= last;
    end
  end

  // Stage 2: table read
  bfsk_sine_rom #(
    .TABLE_ADDRESS_BITS(TABLE_ADDRESS_BITS)
  ) u_rom (
    .clk    (clk),
    .rd_en  (s2_load),
    .addr_a (s1_sidx_r),
    .addr_b (s1_cidx_r),
    .data_a (smag),
    .data_b (cmag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_load) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_sneg_r <= s1_sneg_r;
      s2_cneg_r <= s1_cneg_r;
      s2_bit_r  <= s1_bit_r;
      s2_last_r <= s1_last_r;
    end
  end

  // Scale by amplitude, truncate toward zero, apply sign
  always_comb begin
    sprod      = smag * amp_r;
    cprod      = cmag * amp_r;
    sscaled    = sprod[2*bfsk_pkg::MAG_W-1:bfsk_pkg::MAG_W];
    cscaled    = cprod[2*bfsk_pkg::MAG_W-1:bfsk_pkg::MAG_W];
    first_nxt  = s2_sneg_r ? -$signed({1'b0, sscaled}) : $signed({1'b0, sscaled});
    second_nxt = s2_cneg_r ? -$signed({1'b0, cscaled}) : $signed({1'b0, cscaled});
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
      bit_r    <= s2_bit_r;
      last_r   <= s2_last_r;
    end
  end

  assign out_ch.valid            = out_v_r;
  assign out_ch.first_component  = first_r;
  assign out_ch.second_component = second_r;
  assign out_ch.current_bit      = bit_r;
  assign out_ch.last_of_frame    = last_r;

endmodule

// ----- rtl/core/bfsk_core_checker.sv -----
// ----------------------------------------------------------------------------
// bfsk_core_checker
// Port-level checks on the modulator core: reset, stall, fill and range.
// ----------------------------------------------------------------------------
module bfsk_core_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [bfsk_pkg::SAMPLE_W-1:0] first_component,
  input logic signed [bfsk_pkg::SAMPLE_W-1:0] second_component,
  input logic                                current_bit,
  input logic                                last_of_frame
);

  // Count transactions in flight
  logic [2:0] cnt_r, cnt_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) begin
      cnt_nxt = cnt_r + 3'd1;
    end else if (!in_acc && out_acc) begin
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Reset drops the output
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Stalled sample holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(first_component) &&
      $stable(second_component) && $stable(current_bit) && $stable(last_of_frame))
    else $error("stalled sample changed");

  // Pipeline takes a sample whenever a stage is free
  a_fill_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < 3'd3 |-> in_ready)
    else $error("input stalled with a free stage");

  // No sample shows without a request behind it
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 3'd0)
    else $error("sample without a request");

  // Components stay symmetric
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> first_component != 16'sh8000 && second_component != 16'sh8000)
    else $error("component out of range");

endmodule

bind binary_fsk_iq_modulator_core bfsk_core_checker u_bfsk_core_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .first_component  (out_ch.first_component),
  .second_component (out_ch.second_component),
  .current_bit      (out_ch.current_bit),
  .last_of_frame    (out_ch.last_of_frame)
);

// ----- sim/binary_fsk_iq_modulator_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_fsk_iq_modulator_core_tb
// Self-checking bench for the binary FSK I/Q modulator core. A directed script
// covers the register extremes, zero samples per bit, a phase step past half a
// turn, restarts inside a bit and samples per bit lowered inside a bit. Random
// segments follow under changing settings and flow control. Every sample is
// checked against a script value or an in-bench frame, phase and sine model.
// ----------------------------------------------------------------------------
module binary_fsk_iq_modulator_core_tb;

  localparam int          ROM_BITS     = 10;
  localparam int          ROM_TOP      = 1 << ROM_BITS;
  localparam int          FRAME_LEN    = 64;
  localparam logic [63:0] HALF_PI_FX   = 64'h0000_0192_1FB5_4443;
  localparam int          QUIET_LIMIT  = 2000;
  localparam int          LONG_HOLD    = 60;
  localparam int          SEGMENTS     = 6;
  localparam int          SEG_ITEMS    = 75;
  localparam int          SCRIPT_LEN   = 40;

  typedef struct packed {
    logic signed [bfsk_pkg::SAMPLE_W-1:0] first_c;
    logic signed [bfsk_pkg::SAMPLE_W-1:0] second_c;
    logic                                 bit_val;
    logic                                 frame_end;
  } iq_sample_t;

  typedef struct packed {
    logic                 is_cfg;
    bfsk_pkg::cfg_reg_t   reg_sel;
    logic [63:0]          value;
    logic                 restart;
    logic                 typed_exp;
    iq_sample_t           want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [bfsk_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bfsk_pkg::CFG_DATA_W-1:0] cfg_data;

  bfsk_in_if  req_if ();
  bfsk_out_if smp_if ();

  binary_fsk_iq_modulator_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_if),
    .out_ch    (smp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Model state: registers, frame position, phase and the sine table
  logic [14:0]  sine_rom [0:ROM_TOP];
  logic [63:0]  word_reg;
  logic [19:0]  spb_reg;
  logic [31:0]  step_reg;
  logic [14:0]  amp_reg;
  logic [5:0]   bit_pos;
  logic [19:0]  sample_idx;
  logic [31:0]  phase_acc;

  iq_sample_t expected_q [$];
  int mismatches      = 0;
  int samples_checked = 0;
  int tx_idle_pct     = 33;
  int rx_idle_pct     = 88;
  int hold_requests   = 0;
  int hold_seen;
  int hold_left;
  int quiet_cycles;

  // Directed script: register writes and sample requests, in order
  script_row_t script [SCRIPT_LEN] = '{
    '{1'b0, bfsk_pkg::REG_DATA_WORD, 64'd0, 1'b0, 1'b0, '0},
    '{1'b0, bfsk_pkg::REG_DATA_WORD, 64'd0, 1'b1, 1'b0, '0},
    '{1'b1, bfsk_pkg::REG_AMPLITUDE, 64'd0, 1'b0, 1'b0, '0},
    '{1'b1, bfsk_pkg::REG_SAMPLES_PER_BIT, 64'd1, 1'b0, 1'b0, '0},
    '{1'b1, bfsk_pkg::REG_PHASE_STEP, 64'd0, 1'b0, 1'b0, '0},
    '{1'b1, bfsk_pkg::REG_DATA_WORD, 64'd5, 1'b0, 1'b0, '0},
    '{1'b0, bfsk_pkg::REG_DATA_WORD, 64'd0, 1'b1, 1'b1, '{16'sd0, 16'sd0, 1'b1, 1'b0}},
    '{1'b0, bfsk_pkg::REG_DATA_WORD, 64'd0, 1'b0, 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b0}},
    '{1'b0, bfsk_pkg::REG_DATA_WORD, 64'd0, 1'b0, 1'b1, '{16'sd0, 16'sd0, 1'b1, 1'b0}},
    '{1'b0, bfsk_pkg::REG_DATA_WORD, 64'd0, 1'b1, 1'b1, '{16'sd0, 16'sd0, 1'b1, 1'b0}},
    '{1'b1, bfsk_pkg::REG_AMPLITUDE, 64'd32767, 1'b0, 1'b0, '0},
    '{1'b1, bfsk_pkg::REG_PHASE_STEP, 64'h8000_0000, 1'b0, 1'b0, '0},
    '{1'b1, bfsk_pkg::REG_SAMPLES_PER_BIT, 64'd2, 1'b0, 1'b0, '0},
    '{1'b0, bfsk_pkg::REG_DATA_WORD, 64'd0, 1'b1, 1'b0, '0},
    '{1'b0, bfsk_pkg::REG_DATA_WORD, 64'd0, 1'b0, 1'b0, '0},
    '{1'b0, bfsk_pkg::REG_DATA_WORD, 64'd0, 1'b0, 1'b0, '0},
    '{1'b0, bfsk_pkg::REG_DATA_WORD, 64'd0, 1'b0, 1'b0, '0},
    '{1'b1, bfsk_pkg::REG_PHASE_STEP, 64'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{1'b1, bfsk_pkg::REG_SAMPLES_PER_BIT, 64'd3, 1'b0, 1'b0, '0},
    '{1'b1, bfsk_pkg::REG_DATA_WORD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
    '{1'b0, bfsk_pkg::REG_DATA_WORD, 64'd0, 1'b1, 1'b0, '0},
    '{1'b0, bfsk_pkg::REG_DATA_WORD, 64'd0, 1'b0, 1'b0, '0},
    '{1'b0, bfsk_pkg::REG_DATA_WORD, 64'd0, 1'b1, 1'b0, '0},
    '{1'b0, bfsk_pkg::REG_DATA_WORD, 64'd0, 1'b0, 1'b0, '0},
    '{1'b1, bfsk_pkg::REG_DATA_WORD, 64'd0, 1'b0, 1'b0, '0},
    '{1'b1, bfsk_pkg::REG_SAMPLES_PER_BIT, 64'd0, 1'b0, 1'b0, '0},
    '{1'b0, bfsk_pkg::REG_DATA_WORD, 64'd0, 1'b0, 1'b0, '0},
    '{1'b0, bfsk_pkg::REG_DATA_WORD, 64'd0, 1'b0, 1'b0, '0},
    '{1'b1, bfsk_pkg::REG_SAMPLES_PER_BIT, 64'd5, 1'b0, 1'b0, '0},
    '{1'b1, bfsk_pkg::REG_PHASE_STEP, 64'h1234_5678, 1'b0, 1'b0, '0},
    '{1'b0, bfsk_pkg::REG_DATA_WORD, 64'd0, 1'b1, 1'b0, '0},
    '{1'b0, bfsk_pkg::REG_DATA_WORD, 64'd0, 1'b0, 1'b0, '0},
    '{1'b0, bfsk_pkg::REG_DATA_WORD, 64'd0, 1'b0, 1'b0, '0},
    '{1'b0, bfsk_pkg::REG_DATA_WORD, 64'd0, 1'b0, 1'b0, '0},
    '{1'b1, bfsk_pkg::REG_SAMPLES_PER_BIT, 64'd2, 1'b0, 1'b0, '0},
    '{1'b0, bfsk_pkg::REG_DATA_WORD, 64'd0, 1'b0, 1'b0, '0},
    '{1'b0, bfsk_pkg::REG_DATA_WORD, 64'd0, 1'b0, 1'b0, '0},
    '{1'b1, bfsk_pkg::REG_SAMPLES_PER_BIT, 64'hF_FFFF, 1'b0, 1'b0, '0},
    '{1'b0, bfsk_pkg::REG_DATA_WORD, 64'd0, 1'b1, 1'b0, '0},
    '{1'b0, bfsk_pkg::REG_DATA_WORD, 64'd0, 1'b0, 1'b0, '0}
  };

  // Fill the quarter-wave table from a Q30 Taylor series of sin(x)
  function automatic void build_sine_rom();
    longint unsigned x;
    longint unsigned term;
    longint unsigned v;
    longint          acc;
    for (int k = 0; k <= ROM_TOP; k++) begin
      x    = (longint'(k) * HALF_PI_FX + (64'd1 << (ROM_BITS + 9))) >> (ROM_BITS + 10);
      acc  = longint'(x);
      term = x;
      for (int n = 1; n <= 8; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      v = (longint'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      sine_rom[k] = v[14:0];
    end
  endfunction

  // Amplitude times the sine of a phase, truncated toward zero; flip negates
  function automatic logic [15:0] scaled_sine(input logic [31:0] ph, input logic flip);
    logic [10:0] idx;
    logic [31:0] prod;
    logic        neg;
    idx = {1'b0, ph[29 -: ROM_BITS]};
    if (ph[30]) begin
      idx = 11'(ROM_TOP) - idx;
    end
    neg  = ph[31] ^ flip;
    prod = (32'(sine_rom[idx]) * 32'(amp_reg)) >> 15;
    if (neg) begin
      prod = 32'd0 - prod;
    end
    return prod[15:0];
  endfunction

  // Form the next sample and advance frame position and phase
  function automatic iq_sample_t next_sample(input logic restart_bit);
    iq_sample_t  s;
    logic [19:0] spb_eff;
    logic        ends;
    if (restart_bit) begin
      bit_pos    = '0;
      sample_idx = '0;
      phase_acc  = '0;
    end
    spb_eff     = (spb_reg == '0) ? 20'd1 : spb_reg;
    s.bit_val   = word_reg[bit_pos];
    s.first_c   = scaled_sine(phase_acc, ~s.bit_val);
    s.second_c  = scaled_sine(phase_acc + 32'h4000_0000, 1'b0);
    ends        = (32'(sample_idx) + 32'd1 >= 32'(spb_eff));
    s.frame_end = ends && (int'(bit_pos) + 1 >= FRAME_LEN);
    if (ends) begin
      sample_idx = '0;
      phase_acc  = '0;
      bit_pos    = s.frame_end ? 6'd0 : bit_pos + 6'd1;
    end else begin
      sample_idx = sample_idx + 20'd1;
      phase_acc  = phase_acc + step_reg;
    end
    return s;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("%0t ns: sample %0d %s mismatch: got %0d, expected %0d",
             $time, samples_checked, what, got, want);
  endtask

  // Write one register; the caller drops the write enable after the burst
  task automatic cfg_write(input bfsk_pkg::cfg_reg_t idx, input logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      bfsk_pkg::REG_DATA_WORD:       word_reg = value;
      bfsk_pkg::REG_SAMPLES_PER_BIT: spb_reg  = value[19:0];
      bfsk_pkg::REG_PHASE_STEP:      step_reg = value[31:0];
      bfsk_pkg::REG_AMPLITUDE:       amp_reg  = value[14:0];
      default: ;
    endcase
  endtask

  // Hold until every predicted sample has come out
  task automatic drain_samples();
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  // Offer one sample request and queue its expected sample once accepted
  task automatic send_request(input logic restart_bit, input logic typed_exp,
                              input iq_sample_t typed_val);
    iq_sample_t pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.restart <= restart_bit;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pred = next_sample(restart_bit);
    expected_q.insert(expected_q.size(), typed_exp ? typed_val : pred);
  endtask

  // Load one random setting per segment, with extremes on some segments
  task automatic program_segment(input int seg);
    logic [63:0] cfg_word;
    logic [19:0] cfg_spb;
    logic [31:0] cfg_step;
    logic [14:0] cfg_amp;
    cfg_word = {$urandom, $urandom};
    cfg_spb  = 20'($urandom_range(1, 5));
    cfg_step = $urandom;
    cfg_amp  = 15'($urandom_range(0, 32767));
    case (seg)
      0: begin cfg_spb = 20'd1; cfg_amp = 15'h7FFF; end
      1: begin cfg_spb = '0; cfg_step = '1; end
      2: cfg_step = 32'h8000_0000;
      3: cfg_word = '1;
      5: cfg_spb = '1;
      default: ;
    endcase
    cfg_write(bfsk_pkg::REG_DATA_WORD, cfg_word);
    cfg_write(bfsk_pkg::REG_SAMPLES_PER_BIT, 64'(cfg_spb));
    cfg_write(bfsk_pkg::REG_PHASE_STEP, 64'(cfg_step));
    cfg_write(bfsk_pkg::REG_AMPLITUDE, 64'(cfg_amp));
    cfg_we <= 1'b0;
  endtask

  // Sink side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      smp_if.ready <= 1'b0;
      hold_seen    <= 0;
      hold_left    <= 0;
    end else if (hold_seen != hold_requests) begin
      hold_seen    <= hold_requests;
      hold_left    <= LONG_HOLD;
      smp_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      smp_if.ready <= 1'b0;
    end else begin
      smp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each output transaction with the oldest expectation
  always @(posedge clk) begin : check_output
    iq_sample_t want;
    if (rst_n && smp_if.valid && smp_if.ready) begin
      if (expected_q.size() == 0) begin
        flag_mismatch("unexpected sample, current_bit", longint'(smp_if.current_bit), 0);
      end else begin
        want = expected_q.pop_front();
        if (smp_if.first_component !== want.first_c)
          flag_mismatch("first_component", longint'(smp_if.first_component),
                        longint'(want.first_c));
        if (smp_if.second_component !== want.second_c)
          flag_mismatch("second_component", longint'(smp_if.second_component),
                        longint'(want.second_c));
        if (smp_if.current_bit !== want.bit_val)
          flag_mismatch("current_bit", longint'(smp_if.current_bit),
                        longint'(want.bit_val));
        if (smp_if.last_of_frame !== want.frame_end)
          flag_mismatch("last_of_frame", longint'(smp_if.last_of_frame),
                        longint'(want.frame_end));
      end
      samples_checked++;
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (smp_if.valid && smp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic prev_cfg;
    logic restart_bit;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    req_if.valid   = 1'b0;
    req_if.restart = 1'b0;
    build_sine_rom();
    word_reg   = 64'hAB42_F58C_15AC_FE37;
    spb_reg    = 20'd80000;
    step_reg   = 32'd2684355;
    amp_reg    = 15'd2000;
    bit_pos    = '0;
    sample_idx = '0;
    phase_acc  = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed script
    prev_cfg = 1'b0;
    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        if (!prev_cfg) begin
          req_if.valid <= 1'b0;
          drain_samples();
        end
        cfg_write(script[i].reg_sel, script[i].value);
      end else begin
        if (prev_cfg) begin
          cfg_we <= 1'b0;
        end
        send_request(script[i].restart, script[i].typed_exp, script[i].want);
      end
      prev_cfg = script[i].is_cfg;
    end

    // Random segments under changing settings and flow control
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 2) begin
        tx_idle_pct = 33;
        rx_idle_pct = 88;
      end else if (seg < 4) begin
        tx_idle_pct = 88;
        rx_idle_pct = 33;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      req_if.valid <= 1'b0;
      drain_samples();
      program_segment(seg);
      for (int i = 0; i < SEG_ITEMS; i++) begin
        // fill the pipeline against a long sink stall
        if (seg == 4 && i == 10) begin
          hold_requests <= hold_requests + 1;
        end
        // pause the source until everything is out
        if (seg == 0 && i == 40) begin
          req_if.valid <= 1'b0;
          drain_samples();
        end
        restart_bit = (seg > 1) && ($urandom_range(49) == 0);
        send_request(restart_bit, 1'b0, '0);
      end
    end

    req_if.valid <= 1'b0;
    drain_samples();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
